/* rtl/shfp_pkg.sv */
// Package for the sync-header frame parser: frame constants, the queue item type
// and the byte-wise CRC-32 update.
// Used by the front end, queue, back end, top level and checker; depends on nothing.
package shfp_pkg;

    localparam logic [7:0]  SYNC1_BYTE     = 8'hAA;
    localparam logic [7:0]  SYNC2_BYTE     = 8'h44;
    localparam logic [7:0]  SYNC3_BYTE     = 8'h18;

    localparam int          HEADER_BYTES   = 20;
    localparam int          LENGTH_OFFSET  = 12;

    localparam logic [31:0] CRC_POLY       = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT       = 32'hFFFFFFFF;
    localparam logic [15:0] CRC_BYTES      = 16'd4;

    localparam logic [15:0] MAX_LEN_RESET  = 16'd4096;

    // Register map: one register per 32-bit word.
    localparam int          ADDR_W         = 3;
    localparam logic        REG_MAX_LEN    = 1'b0;

    localparam int          QUEUE_DEPTH    = 4;
    localparam int          QUEUE_AW       = $clog2(QUEUE_DEPTH);

    // One received byte with its sync-byte classification.
    typedef struct packed {
        logic [7:0] data;
        logic       is_sync1;
        logic       is_sync2;
        logic       is_sync3;
    } shfp_item_t;

    // Reflected CRC-32 over one byte, least significant bit first.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

/* rtl/shfp_if.sv */
// Valid/ready stream interfaces of the frame parser: received bytes in, results out.
// Depends on nothing.
interface shfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface shfp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       in_frame;
    logic       frame_end;
    logic       crc_good;
    logic       oversize_drop;

    modport source (output valid, output out_byte, output in_frame, output frame_end,
                    output crc_good, output oversize_drop, input ready);
    modport sink   (input valid, input out_byte, input in_frame, input frame_end,
                    input crc_good, input oversize_drop, output ready);
endinterface

/* rtl/shfp_front.sv */
// Front end of the frame parser: takes bytes from the input stream, registers them and
// marks the sync bytes before they enter the queue.
// Depends on shfp_pkg and shfp_in_if.
module shfp_front (
    input  logic                clk,
    input  logic                rst_n,
    shfp_in_if.sink             rx,
    input  logic                queue_full,
    output logic                push,
    output shfp_pkg::shfp_item_t push_item
);

    logic                 valid_reg;
    logic                 valid_next;
    shfp_pkg::shfp_item_t item_reg;
    shfp_pkg::shfp_item_t item_next;
    logic                 take;

    assign push     = valid_reg && !queue_full;
    assign rx.ready = !valid_reg || !queue_full;
    assign take     = rx.valid && rx.ready;

    always_comb
    begin
        item_next          = item_reg;
        item_next.data     = rx.in_byte;
        item_next.is_sync1 = (rx.in_byte == shfp_pkg::SYNC1_BYTE);
        item_next.is_sync2 = (rx.in_byte == shfp_pkg::SYNC2_BYTE);
        item_next.is_sync3 = (rx.in_byte == shfp_pkg::SYNC3_BYTE);
        valid_next         = take || (valid_reg && !push);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

    assign push_item = item_reg;

endmodule

/* rtl/shfp_queue.sv */
// Short first-in first-out queue between the front end and the parser.
// Depends on shfp_pkg for the item type and the depth.
module shfp_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  shfp_pkg::shfp_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output shfp_pkg::shfp_item_t head_item
);

    shfp_pkg::shfp_item_t             mem [shfp_pkg::QUEUE_DEPTH];
    logic [shfp_pkg::QUEUE_AW-1:0]    wr_ptr_reg;
    logic [shfp_pkg::QUEUE_AW-1:0]    wr_ptr_next;
    logic [shfp_pkg::QUEUE_AW-1:0]    rd_ptr_reg;
    logic [shfp_pkg::QUEUE_AW-1:0]    rd_ptr_next;
    logic [shfp_pkg::QUEUE_AW:0]      count_reg;
    logic [shfp_pkg::QUEUE_AW:0]      count_next;
    logic                             do_push;
    logic                             do_pop;

    assign full      = (count_reg == (shfp_pkg::QUEUE_AW+1)'(shfp_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_item = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/shfp_back.sv */
// Back end of the frame parser: the framing state machine, the CRC-32 register and the
// result output register.
// Depends on shfp_pkg and shfp_out_if.
module shfp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  shfp_pkg::shfp_item_t q_item,
    output logic                 pop,
    input  logic [15:0]          max_len,
    shfp_out_if.source           tx
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_SYNC2,
        PH_SYNC3,
        PH_HEADER,
        PH_DATA,
        PH_CRC
    } phase_t;

    localparam logic [31:0] CRC_AFTER_SYNC1 =
        shfp_pkg::crc32_byte(shfp_pkg::CRC_INIT, shfp_pkg::SYNC1_BYTE);

    phase_t      phase_reg,        phase_next;
    logic [4:0]  header_count_reg, header_count_next;
    logic [7:0]  length_low_reg,   length_low_next;
    logic [15:0] bytes_left_reg,   bytes_left_next;
    logic [31:0] crc_reg,          crc_next;

    logic        out_valid_reg,    out_valid_next;
    logic [7:0]  out_byte_reg,     out_byte_next;
    logic        in_frame_reg,     in_frame_next;
    logic        frame_end_reg,    frame_end_next;
    logic        crc_good_reg,     crc_good_next;
    logic        drop_reg,         drop_next;

    logic [31:0] crc_upd;
    logic [15:0] left_dec;
    logic [7:0]  b;

    assign pop = q_valid && (!out_valid_reg || tx.ready);
    assign b   = q_item.data;

    always_comb
    begin
        phase_next        = phase_reg;
        header_count_next = header_count_reg;
        length_low_next   = length_low_reg;
        bytes_left_next   = bytes_left_reg;
        crc_next          = crc_reg;
        out_valid_next    = out_valid_reg && !tx.ready;
        out_byte_next     = out_byte_reg;
        in_frame_next     = in_frame_reg;
        frame_end_next    = frame_end_reg;
        crc_good_next     = crc_good_reg;
        drop_next         = drop_reg;
        crc_upd           = shfp_pkg::crc32_byte(crc_reg, b);
        left_dec          = bytes_left_reg - 16'd1;

        if (pop)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = b;
            in_frame_next  = 1'b1;
            frame_end_next = 1'b0;
            crc_good_next  = 1'b0;
            drop_next      = 1'b0;

            // A byte that breaks the sync sequence may itself open a new frame.
            if ((phase_reg == PH_SYNC2 && q_item.is_sync2) ||
                (phase_reg == PH_SYNC3 && q_item.is_sync3))
            begin
                crc_next          = crc_upd;
                header_count_next = header_count_reg + 5'd1;
                phase_next        = (phase_reg == PH_SYNC2) ? PH_SYNC3 : PH_HEADER;
            end
            else
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        crc_next = crc_upd;
                        if (header_count_reg == 5'(shfp_pkg::LENGTH_OFFSET))
                        begin
                            length_low_next = b;
                        end
                        else if (header_count_reg == 5'(shfp_pkg::LENGTH_OFFSET + 1))
                        begin
                            bytes_left_next = {b, length_low_reg};
                        end
                        header_count_next = header_count_reg + 5'd1;
                        if (header_count_next >= 5'(shfp_pkg::HEADER_BYTES))
                        begin
                            if (bytes_left_next > max_len)
                            begin
                                drop_next  = 1'b1;
                                phase_next = PH_HUNT;
                            end
                            else if (bytes_left_next == 16'd0)
                            begin
                                crc_next        = ~crc_upd;
                                bytes_left_next = shfp_pkg::CRC_BYTES;
                                phase_next      = PH_CRC;
                            end
                            else
                            begin
                                phase_next = PH_DATA;
                            end
                        end
                    end
                    PH_DATA:
                    begin
                        crc_next        = crc_upd;
                        bytes_left_next = left_dec;
                        if (left_dec == 16'd0)
                        begin
                            crc_next        = ~crc_upd;
                            bytes_left_next = shfp_pkg::CRC_BYTES;
                            phase_next      = PH_CRC;
                        end
                    end
                    PH_CRC:
                    begin
                        crc_next        = crc_upd;
                        bytes_left_next = left_dec;
                        if (left_dec == 16'd0)
                        begin
                            frame_end_next = 1'b1;
                            crc_good_next  = (crc_upd == 32'd0);
                            phase_next     = PH_HUNT;
                        end
                    end
                    default:
                    begin
                        // Hunting, or a sync byte that did not match.
                        if (q_item.is_sync1)
                        begin
                            crc_next          = CRC_AFTER_SYNC1;
                            header_count_next = 5'd1;
                            length_low_next   = 8'd0;
                            bytes_left_next   = 16'd0;
                            phase_next        = PH_SYNC2;
                        end
                        else
                        begin
                            in_frame_next = 1'b0;
                            phase_next    = PH_HUNT;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HUNT;
            header_count_reg <= 5'd0;
            length_low_reg   <= 8'd0;
            bytes_left_reg   <= 16'd0;
            crc_reg          <= shfp_pkg::CRC_INIT;
            out_valid_reg    <= 1'b0;
            out_byte_reg     <= 8'd0;
            in_frame_reg     <= 1'b0;
            frame_end_reg    <= 1'b0;
            crc_good_reg     <= 1'b0;
            drop_reg         <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            header_count_reg <= header_count_next;
            length_low_reg   <= length_low_next;
            bytes_left_reg   <= bytes_left_next;
            crc_reg          <= crc_next;
            out_valid_reg    <= out_valid_next;
            out_byte_reg     <= out_byte_next;
            in_frame_reg     <= in_frame_next;
            frame_end_reg    <= frame_end_next;
            crc_good_reg     <= crc_good_next;
            drop_reg         <= drop_next;
        end
    end

    assign tx.valid         = out_valid_reg;
    assign tx.out_byte      = out_byte_reg;
    assign tx.in_frame      = in_frame_reg;
    assign tx.frame_end     = frame_end_reg;
    assign tx.crc_good      = crc_good_reg;
    assign tx.oversize_drop = drop_reg;

endmodule

/* rtl/sync_header_frame_parser_crc32.sv */
// Sync-header frame parser with CRC-32 check.
//
// Bytes arrive on the rx stream, one per transfer, and every byte yields exactly one
// result transfer on the tx stream: the byte itself, whether it belongs to a frame,
// a frame-end mark with the CRC verdict, and an oversize-drop mark on the last header
// byte of a frame whose length field exceeds the max_len limit.
// The limit is written over the APB port at byte addresses 0 to 3, which also read it
// back; other addresses read zero and pready is always high. Write it only while no bytes are in flight.
//
// Throughput is one byte per clock cycle while tx is not stalled, set by the byte-wide
// CRC update and the framing state machine in the back end. Each input byte crosses
// the front register, the queue and the output register before its result is offered.
// A four-entry queue separates the front end from the parser, so a stalled receiver on
// tx fills the output register, the queue and then the front register before rx drops
// ready; nothing is lost. Reset empties the queue, returns the parser to hunting for the
// first sync byte, sets the CRC register to all ones and the limit to 4096.
// Depends on shfp_pkg, shfp_if, shfp_front, shfp_queue and shfp_back.
module sync_header_frame_parser_crc32 (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [shfp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    shfp_in_if.sink                     rx,
    shfp_out_if.source                  tx
);

    logic [15:0]          max_len_reg;
    logic [15:0]          max_len_next;
    logic                 sel_max_len;
    logic                 push;
    logic                 pop;
    logic                 q_full;
    logic                 q_valid;
    shfp_pkg::shfp_item_t push_item;
    shfp_pkg::shfp_item_t head_item;

    assign pready      = 1'b1;
    assign sel_max_len = (paddr[shfp_pkg::ADDR_W-1] == shfp_pkg::REG_MAX_LEN);
    assign prdata      = sel_max_len ? {16'd0, max_len_reg} : 32'd0;

    always_comb
    begin
        max_len_next = max_len_reg;
        if (psel && penable && pwrite && pready && sel_max_len)
        begin
            max_len_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= shfp_pkg::MAX_LEN_RESET;
        end
        else
        begin
            max_len_reg <= max_len_next;
        end
    end

    shfp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .queue_full (q_full),
        .push       (push),
        .push_item  (push_item)
    );

    shfp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_valid),
        .head_item (head_item)
    );

    shfp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (head_item),
        .pop     (pop),
        .max_len (max_len_reg),
        .tx      (tx)
    );

endmodule

/* rtl/shfp_checker.sv */
// Port-level checks for the sync-header frame parser, attached to the top level by bind.
// Depends on sync_header_frame_parser_crc32 and shfp_pkg.
module shfp_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [shfp_pkg::ADDR_W-1:0] paddr,
    input logic [31:0]                 pwdata,
    input logic [31:0]                 prdata,
    input logic                        tx_valid,
    input logic                        tx_ready,
    input logic [7:0]                  tx_byte,
    input logic                        tx_in_frame,
    input logic                        tx_frame_end,
    input logic                        tx_crc_good,
    input logic                        tx_drop
);

    // A stalled result must be held unchanged.
    a_tx_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && !tx_ready |=> tx_valid && $stable(tx_byte) && $stable(tx_in_frame)
            && $stable(tx_frame_end) && $stable(tx_crc_good) && $stable(tx_drop))
        else $error("result changed while stalled");

    // The frame end and the CRC verdict only come on a byte inside a frame, the verdict only with a frame end.
    a_end_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && (tx_frame_end || tx_crc_good) |-> tx_in_frame && tx_frame_end)
        else $error("frame end or CRC verdict outside a frame");

    // A dropped header is always inside a frame and never also the end of a frame.
    a_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && tx_drop |-> tx_in_frame && !tx_frame_end)
        else $error("oversize drop flagged with frame end");

    // The limit register reads back the low 16 bits of what was written to it.
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && paddr == '0 ##1 paddr == '0
            |-> prdata == {16'd0, $past(pwdata[15:0])})
        else $error("limit register read-back mismatch");

endmodule

bind sync_header_frame_parser_crc32 shfp_checker u_shfp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .tx_valid     (tx.valid),
    .tx_ready     (tx.ready),
    .tx_byte      (tx.out_byte),
    .tx_in_frame  (tx.in_frame),
    .tx_frame_end (tx.frame_end),
    .tx_crc_good  (tx.crc_good),
    .tx_drop      (tx.oversize_drop)
);
